/* rtl/vvp_pkg.sv */
package vvp_pkg;

    // default datapath widths, handed to the top level parameters
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_WIDTH_DEF  = 16;

    // fixed field widths of the vertex and result channels
    localparam int VERTEX_W = 32;
    localparam int SCREEN_W = 40;
    localparam int DEPTH_W  = 32;

    // projection coefficients: signed Q12.12, packed two to a register
    localparam int PROJ_COEF_W = 24;
    localparam int PROJ_FRAC   = 12;
    localparam int PROJ_REG_W  = 2 * PROJ_COEF_W;

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COS_ANGLES = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIN_ANGLES = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PROJ_X     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PROJ_Y     = 3'd6;

    // pipeline: offset, then multiply and sum for each of three rotations,
    // then multiply and sum for the projection
    localparam int N_STAGES = 9;
    localparam int N_ROT    = 3;

    // rotation order Y, X, Z: lanes 0 = x, 1 = y, 2 = z
    // trig field 0 = z angle, 1 = y angle, 2 = x angle
    localparam logic [1:0] ROT_LANE_A [N_ROT] = '{2'd0, 2'd1, 2'd0};
    localparam logic [1:0] ROT_LANE_B [N_ROT] = '{2'd2, 2'd2, 2'd1};
    localparam logic [1:0] ROT_LANE_P [N_ROT] = '{2'd1, 2'd0, 2'd2};
    localparam logic [1:0] ROT_FIELD  [N_ROT] = '{2'd1, 2'd2, 2'd0};

endpackage

/* rtl/vvp_if.sv */
interface vvp_vertex_if;
    import vvp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VERTEX_W-1:0] vertex_x;
    logic signed [VERTEX_W-1:0] vertex_y;
    logic signed [VERTEX_W-1:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

interface vvp_result_if;
    import vvp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic signed [DEPTH_W-1:0]  depth;
    logic                       overflow;

    modport source (output valid, output screen_x, output screen_y, output depth,
                    output overflow, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input depth,
                    input overflow, output ready);
endinterface

/* rtl/vertex_view_projection.sv */
// channel   direction  handshake              payload
// vin       in         valid / ready          vertex_x, vertex_y, vertex_z
// vout      out        valid / ready          screen_x, screen_y, depth, overflow
// apb       in         psel, penable, pready  paddr, pwdata, prdata
//
// one vertex per clock sustained while vout is ready; a vin transfer reaches
// vout through one stage for the offset add and a multiply stage plus a
// sum stage for each rotation and for the projection
// rst_n clears the valid bits and loads the register defaults
// each stage holds while the one after it is full and stalled, so bubbles
// close up and vin stays ready until every stage holds a vertex and vout stalls
module vertex_view_projection #(
    parameter int COORD_WIDTH = vvp_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = vvp_pkg::TRIG_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vvp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vvp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vvp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    vvp_vertex_if.sink                      vin,
    vvp_result_if.source                    vout
);
    import vvp_pkg::*;

    localparam int CW          = COORD_WIDTH;
    localparam int TRIG_FRAC   = TRIG_WIDTH - 2;
    localparam int TRIG_ALL_W  = 3 * TRIG_WIDTH;
    localparam int TRIG_REG_W  = (TRIG_ALL_W > APB_DATA_W) ? APB_DATA_W : TRIG_ALL_W;

    localparam int OFF_SUM_W   = VERTEX_W + 1;
    localparam int OFF_W       = (CW > OFF_SUM_W) ? CW : OFF_SUM_W;

    localparam int ROT_COEF_W  = TRIG_WIDTH + 1;
    localparam int ROT_PROD_W  = CW + ROT_COEF_W;
    localparam int ROT_SUM_W   = ROT_PROD_W + 1;

    localparam int PCOEF_W     = PROJ_COEF_W + 1;
    localparam int PROJ_PROD_W = CW + PCOEF_W;
    localparam int PROJ_SUM_W  = PROJ_PROD_W + 1;

    localparam int DEP_W       = (CW > DEPTH_W) ? CW : DEPTH_W;

    // saturation bounds, sign-extended into the width being checked
    localparam logic signed [OFF_W-1:0] OFF_MAX =
        {{(OFF_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN =
        {{(OFF_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
    localparam logic signed [ROT_SUM_W-1:0] ROT_MAX =
        {{(ROT_SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [ROT_SUM_W-1:0] ROT_MIN =
        {{(ROT_SUM_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
    localparam logic signed [PROJ_SUM_W-1:0] SCR_MAX =
        {{(PROJ_SUM_W - SCREEN_W + 1){1'b0}}, {(SCREEN_W - 1){1'b1}}};
    localparam logic signed [PROJ_SUM_W-1:0] SCR_MIN =
        {{(PROJ_SUM_W - SCREEN_W + 1){1'b1}}, {(SCREEN_W - 1){1'b0}}};
    localparam logic signed [DEP_W-1:0] DEP_MAX =
        {{(DEP_W - DEPTH_W + 1){1'b0}}, {(DEPTH_W - 1){1'b1}}};
    localparam logic signed [DEP_W-1:0] DEP_MIN =
        {{(DEP_W - DEPTH_W + 1){1'b1}}, {(DEPTH_W - 1){1'b0}}};

    // half an lsb for round to nearest
    localparam logic signed [ROT_SUM_W-1:0] ROT_HALF =
        {{(ROT_SUM_W - TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC - 1){1'b0}}};
    localparam logic signed [PROJ_SUM_W-1:0] PROJ_HALF =
        {{(PROJ_SUM_W - PROJ_FRAC){1'b0}}, 1'b1, {(PROJ_FRAC - 1){1'b0}}};

    // cosine fields of 1.0 after reset
    localparam logic [TRIG_ALL_W-1:0] COS_ONE = {3{2'b01, {TRIG_FRAC{1'b0}}}};
    localparam logic [TRIG_REG_W-1:0] COS_RESET = COS_ONE[TRIG_REG_W-1:0];

    // stage numbers
    localparam int ST_OFF   = 0;
    localparam int ST_PMUL  = 2 * N_ROT + 1;
    localparam int ST_OUT   = N_STAGES - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VERTEX_W-1:0]   off_x_reg;
    logic [VERTEX_W-1:0]   off_y_reg;
    logic [VERTEX_W-1:0]   off_z_reg;
    logic [TRIG_REG_W-1:0] cos_reg;
    logic [TRIG_REG_W-1:0] sin_reg;
    logic [PROJ_REG_W-1:0] projx_reg;
    logic [PROJ_REG_W-1:0] projy_reg;

    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            cos_reg   <= COS_RESET;
            sin_reg   <= '0;
            projx_reg <= '0;
            projy_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_OFFSET_X:   off_x_reg <= pwdata[VERTEX_W-1:0];
                REG_OFFSET_Y:   off_y_reg <= pwdata[VERTEX_W-1:0];
                REG_OFFSET_Z:   off_z_reg <= pwdata[VERTEX_W-1:0];
                REG_COS_ANGLES: cos_reg   <= pwdata[TRIG_REG_W-1:0];
                REG_SIN_ANGLES: sin_reg   <= pwdata[TRIG_REG_W-1:0];
                REG_PROJ_X:     projx_reg <= pwdata[PROJ_REG_W-1:0];
                REG_PROJ_Y:     projy_reg <= pwdata[PROJ_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (cfg_idx)
            REG_OFFSET_X:   prdata = APB_DATA_W'(off_x_reg);
            REG_OFFSET_Y:   prdata = APB_DATA_W'(off_y_reg);
            REG_OFFSET_Z:   prdata = APB_DATA_W'(off_z_reg);
            REG_COS_ANGLES: prdata = APB_DATA_W'(cos_reg);
            REG_SIN_ANGLES: prdata = APB_DATA_W'(sin_reg);
            REG_PROJ_X:     prdata = APB_DATA_W'(projx_reg);
            REG_PROJ_Y:     prdata = APB_DATA_W'(projy_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // coefficient unpacking
    // ------------------------------------------------------------------
    logic [TRIG_ALL_W-1:0]          cos_all;
    logic [TRIG_ALL_W-1:0]          sin_all;
    logic signed [ROT_COEF_W-1:0]   rot_c [N_ROT];
    logic signed [ROT_COEF_W-1:0]   rot_s [N_ROT];
    logic signed [ROT_COEF_W-1:0]   rot_ns [N_ROT];
    logic signed [PCOEF_W-1:0]      coef_ax;
    logic signed [PCOEF_W-1:0]      coef_kx;
    logic signed [PCOEF_W-1:0]      coef_nay;
    logic signed [PCOEF_W-1:0]      coef_ky;

    assign cos_all = TRIG_ALL_W'(cos_reg);
    assign sin_all = TRIG_ALL_W'(sin_reg);

    always_comb
    begin
        for (int r = 0; r < N_ROT; r++)
        begin
            rot_c[r]  = ROT_COEF_W'(signed'(cos_all[ROT_FIELD[r]*TRIG_WIDTH +: TRIG_WIDTH]));
            rot_s[r]  = ROT_COEF_W'(signed'(sin_all[ROT_FIELD[r]*TRIG_WIDTH +: TRIG_WIDTH]));
            rot_ns[r] = -rot_s[r];
        end
    end

    assign coef_ax  = PCOEF_W'(signed'(projx_reg[PROJ_REG_W-1:PROJ_COEF_W]));
    assign coef_kx  = PCOEF_W'(signed'(projx_reg[PROJ_COEF_W-1:0]));
    assign coef_nay = -PCOEF_W'(signed'(projy_reg[PROJ_REG_W-1:PROJ_COEF_W]));
    assign coef_ky  = PCOEF_W'(signed'(projy_reg[PROJ_COEF_W-1:0]));

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] adv;
    logic                in_fire;
    logic                out_fire;

    // a stage may load when it is empty or its item moves on
    always_comb
    begin
        adv[ST_OUT] = !vld_reg[ST_OUT] || vout.ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vin.ready  = adv[ST_OFF];
    assign vout.valid = vld_reg[ST_OUT];
    assign in_fire    = vin.valid && vin.ready;
    assign out_fire   = vout.valid && vout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[ST_OFF])
            begin
                vld_reg[ST_OFF] <= vin.valid;
            end
            for (int k = 1; k < N_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0]          crd_reg    [N_ROT+1][3];
    logic signed [ROT_PROD_W-1:0]  rprod_reg  [N_ROT][4];
    logic signed [CW-1:0]          rpass_reg  [N_ROT];
    logic signed [PROJ_PROD_W-1:0] pprod_reg  [4];
    logic signed [CW-1:0]          pz_reg;
    logic [N_STAGES-1:0]           ovf_reg;
    logic signed [SCREEN_W-1:0]    sx_reg;
    logic signed [SCREEN_W-1:0]    sy_reg;
    logic signed [DEPTH_W-1:0]     depth_reg;

    // offset add with saturation
    logic signed [OFF_SUM_W-1:0] off_sum [3];
    logic signed [OFF_W-1:0]     off_ext [3];
    logic signed [CW-1:0]        off_crd_next [3];
    logic                        off_ovf_next;

    always_comb
    begin
        off_sum[0] = OFF_SUM_W'(vin.vertex_x) + OFF_SUM_W'(signed'(off_x_reg));
        off_sum[1] = OFF_SUM_W'(vin.vertex_y) + OFF_SUM_W'(signed'(off_y_reg));
        off_sum[2] = OFF_SUM_W'(vin.vertex_z) + OFF_SUM_W'(signed'(off_z_reg));
        off_ovf_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            off_ext[i] = OFF_W'(off_sum[i]);
            if (off_ext[i] > OFF_MAX)
            begin
                off_crd_next[i] = OFF_MAX[CW-1:0];
                off_ovf_next    = 1'b1;
            end
            else if (off_ext[i] < OFF_MIN)
            begin
                off_crd_next[i] = OFF_MIN[CW-1:0];
                off_ovf_next    = 1'b1;
            end
            else
            begin
                off_crd_next[i] = off_ext[i][CW-1:0];
            end
        end
    end

    // rotation products: a*c, b*s for the new a and a*(-s), b*c for the new b
    logic signed [ROT_PROD_W-1:0] rprod_next [N_ROT][4];

    always_comb
    begin
        for (int r = 0; r < N_ROT; r++)
        begin
            rprod_next[r][0] = ROT_PROD_W'(crd_reg[r][ROT_LANE_A[r]]) * ROT_PROD_W'(rot_c[r]);
            rprod_next[r][1] = ROT_PROD_W'(crd_reg[r][ROT_LANE_B[r]]) * ROT_PROD_W'(rot_s[r]);
            rprod_next[r][2] = ROT_PROD_W'(crd_reg[r][ROT_LANE_A[r]]) * ROT_PROD_W'(rot_ns[r]);
            rprod_next[r][3] = ROT_PROD_W'(crd_reg[r][ROT_LANE_B[r]]) * ROT_PROD_W'(rot_c[r]);
        end
    end

    // rotation sums, rounding and saturation
    logic signed [ROT_SUM_W-1:0] rsum [N_ROT][2];
    logic signed [ROT_SUM_W-1:0] rshr [N_ROT][2];
    logic signed [CW-1:0]        rot_next [N_ROT][2];
    logic [N_ROT-1:0]            rot_ovf_next;

    always_comb
    begin
        for (int r = 0; r < N_ROT; r++)
        begin
            rot_ovf_next[r] = 1'b0;
            for (int j = 0; j < 2; j++)
            begin
                rsum[r][j] = ROT_SUM_W'(rprod_reg[r][2*j]) + ROT_SUM_W'(rprod_reg[r][2*j+1])
                             + ROT_HALF;
                rshr[r][j] = rsum[r][j] >>> TRIG_FRAC;
                if (rshr[r][j] > ROT_MAX)
                begin
                    rot_next[r][j]  = ROT_MAX[CW-1:0];
                    rot_ovf_next[r] = 1'b1;
                end
                else if (rshr[r][j] < ROT_MIN)
                begin
                    rot_next[r][j]  = ROT_MIN[CW-1:0];
                    rot_ovf_next[r] = 1'b1;
                end
                else
                begin
                    rot_next[r][j] = rshr[r][j][CW-1:0];
                end
            end
        end
    end

    // projection products: x*ax, z*cx, y*(-ay), z*cy
    logic signed [PROJ_PROD_W-1:0] pprod_next [4];

    always_comb
    begin
        pprod_next[0] = PROJ_PROD_W'(crd_reg[N_ROT][0]) * PROJ_PROD_W'(coef_ax);
        pprod_next[1] = PROJ_PROD_W'(crd_reg[N_ROT][2]) * PROJ_PROD_W'(coef_kx);
        pprod_next[2] = PROJ_PROD_W'(crd_reg[N_ROT][1]) * PROJ_PROD_W'(coef_nay);
        pprod_next[3] = PROJ_PROD_W'(crd_reg[N_ROT][2]) * PROJ_PROD_W'(coef_ky);
    end

    // projection sums, screen saturation and depth clamp
    logic signed [PROJ_SUM_W-1:0] psum [2];
    logic signed [PROJ_SUM_W-1:0] pshr [2];
    logic signed [SCREEN_W-1:0]   scr_next [2];
    logic signed [DEP_W-1:0]      dep_ext;
    logic signed [DEPTH_W-1:0]    depth_next;
    logic                         proj_ovf_next;

    always_comb
    begin
        proj_ovf_next = 1'b0;
        for (int j = 0; j < 2; j++)
        begin
            psum[j] = PROJ_SUM_W'(pprod_reg[2*j]) + PROJ_SUM_W'(pprod_reg[2*j+1]) + PROJ_HALF;
            pshr[j] = psum[j] >>> PROJ_FRAC;
            if (pshr[j] > SCR_MAX)
            begin
                scr_next[j]   = SCR_MAX[SCREEN_W-1:0];
                proj_ovf_next = 1'b1;
            end
            else if (pshr[j] < SCR_MIN)
            begin
                scr_next[j]   = SCR_MIN[SCREEN_W-1:0];
                proj_ovf_next = 1'b1;
            end
            else
            begin
                scr_next[j] = pshr[j][SCREEN_W-1:0];
            end
        end
        dep_ext = DEP_W'(pz_reg);
        if (dep_ext > DEP_MAX)
        begin
            depth_next    = DEP_MAX[DEPTH_W-1:0];
            proj_ovf_next = 1'b1;
        end
        else if (dep_ext < DEP_MIN)
        begin
            depth_next    = DEP_MIN[DEPTH_W-1:0];
            proj_ovf_next = 1'b1;
        end
        else
        begin
            depth_next = dep_ext[DEPTH_W-1:0];
        end
    end

    // stage payload registers, loaded whenever the stage advances
    always_ff @(posedge clk)
    begin
        if (adv[ST_OFF])
        begin
            crd_reg[0]      <= off_crd_next;
            ovf_reg[ST_OFF] <= off_ovf_next;
        end
        for (int r = 0; r < N_ROT; r++)
        begin
            if (adv[2*r+1])
            begin
                rprod_reg[r]   <= rprod_next[r];
                rpass_reg[r]   <= crd_reg[r][ROT_LANE_P[r]];
                ovf_reg[2*r+1] <= ovf_reg[2*r];
            end
            if (adv[2*r+2])
            begin
                crd_reg[r+1][ROT_LANE_A[r]] <= rot_next[r][0];
                crd_reg[r+1][ROT_LANE_B[r]] <= rot_next[r][1];
                crd_reg[r+1][ROT_LANE_P[r]] <= rpass_reg[r];
                ovf_reg[2*r+2]              <= ovf_reg[2*r+1] | rot_ovf_next[r];
            end
        end
        if (adv[ST_PMUL])
        begin
            pprod_reg        <= pprod_next;
            pz_reg           <= crd_reg[N_ROT][2];
            ovf_reg[ST_PMUL] <= ovf_reg[ST_PMUL-1];
        end
        if (adv[ST_OUT])
        begin
            sx_reg          <= scr_next[0];
            sy_reg          <= scr_next[1];
            depth_reg       <= depth_next;
            ovf_reg[ST_OUT] <= ovf_reg[ST_PMUL] | proj_ovf_next;
        end
    end

    assign vout.screen_x = sx_reg;
    assign vout.screen_y = sy_reg;
    assign vout.depth    = depth_reg;
    assign vout.overflow = ovf_reg[ST_OUT];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // items in flight change only by transfers at either end
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(vld_reg) ==
                  $past($countones(vld_reg)) + int'($past(in_fire)) - int'($past(out_fire))))
        else $error("pipeline occupancy does not match transfers");

    // an accepted vertex occupies the offset stage next cycle
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> vld_reg[ST_OFF])
        else $error("accepted vertex lost at the offset stage");

    // a stalled result keeps its values in the output stage
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_OUT] && !adv[ST_OUT]) |=>
            (vld_reg[ST_OUT] && $stable(sx_reg) && $stable(sy_reg) && $stable(depth_reg)))
        else $error("stalled result changed in the output stage");

endmodule
